// ===== hdl/rssi_proximity_hysteresis_top_assert.svh =====
// Assertion macros shared by the proximity block.
`ifndef RSSI_PROXIMITY_HYSTERESIS_TOP_ASSERT_SVH
`define RSSI_PROXIMITY_HYSTERESIS_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPH_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("proximity block: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define RPH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("proximity block: next-cycle property failed");

`endif

// ===== hdl/rph_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rph_pkg;

    typedef struct packed {
        logic              kind;
        logic signed [7:0] rssi;
        logic [15:0]       elapsed_ms;
    } req_item_t;

    typedef struct packed {
        logic              near;
        logic              changed;
        logic              peer_present;
        logic signed [7:0] filtered_dbm;
    } rsp_item_t;

    typedef struct packed {
        logic [8:0]        alpha;
        logic signed [7:0] near_threshold;
        logic signed [7:0] far_threshold;
        logic [15:0]       timeout_ms;
    } cfg_t;

    // Register indexes on the configuration channel.
    localparam logic [1:0] CFG_ALPHA          = 2'd0;
    localparam logic [1:0] CFG_NEAR_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_FAR_THRESHOLD  = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT_MS     = 2'd3;

    localparam logic [8:0]        ALPHA_RESET     = 9'd77;
    localparam logic signed [7:0] NEAR_THR_RESET  = -8'sd60;
    localparam logic signed [7:0] FAR_THR_RESET   = -8'sd70;
    localparam logic [15:0]       TIMEOUT_RESET   = 16'd3000;

    // Item kinds.
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_STEP   = 1'b1;

    // Alpha of 1.0 in Q1.8, and the filter level after reset (-100 dBm in Q8.8).
    localparam logic [8:0]         ALPHA_ONE   = 9'd256;
    localparam logic signed [15:0] LEVEL_RESET = -16'sd25600;
    localparam logic [16:0]        AGE_MAX     = 17'h1FFFF;

endpackage

`default_nettype wire

// ===== hdl/rph_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rph_req_if;
    logic              valid;
    logic              ready;
    logic              kind;
    logic signed [7:0] rssi;
    logic [15:0]       elapsed_ms;

    modport source (output valid, kind, rssi, elapsed_ms, input ready);
    modport sink   (input valid, kind, rssi, elapsed_ms, output ready);
endinterface

interface rph_rsp_if;
    logic              valid;
    logic              ready;
    logic              near;
    logic              changed;
    logic              peer_present;
    logic signed [7:0] filtered_dbm;

    modport source (output valid, near, changed, peer_present, filtered_dbm, input ready);
    modport sink   (input valid, near, changed, peer_present, filtered_dbm, output ready);
endinterface

interface rph_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/rph_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rph_cfg_regs (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr_en,
    input  wire logic [1:0]   wr_index,
    input  wire logic [15:0]  wr_data,
    output rph_pkg::cfg_t     cfg
);

    rph_pkg::cfg_t cfg_reg;
    rph_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                rph_pkg::CFG_ALPHA:          cfg_next.alpha          = wr_data[8:0];
                rph_pkg::CFG_NEAR_THRESHOLD: cfg_next.near_threshold = wr_data[7:0];
                rph_pkg::CFG_FAR_THRESHOLD:  cfg_next.far_threshold  = wr_data[7:0];
                rph_pkg::CFG_TIMEOUT_MS:     cfg_next.timeout_ms     = wr_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha          <= rph_pkg::ALPHA_RESET;
            cfg_reg.near_threshold <= rph_pkg::NEAR_THR_RESET;
            cfg_reg.far_threshold  <= rph_pkg::FAR_THR_RESET;
            cfg_reg.timeout_ms     <= rph_pkg::TIMEOUT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hdl/rph_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rph_in_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire rph_pkg::req_item_t in_item,
    output logic                    in_ready,
    output logic                    out_valid,
    output rph_pkg::req_item_t      out_item,
    input  wire logic               take
);

    logic               valid_reg;
    logic               valid_next;
    rph_pkg::req_item_t item_reg;
    rph_pkg::req_item_t item_next;

    // The stage refills in the same cycle that the core takes its item.
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
            item_next  = in_item;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// ===== hdl/rph_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rph_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rph_pkg::cfg_t      cfg,
    input  wire logic               item_valid,
    input  wire rph_pkg::req_item_t item,
    output logic                    take,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output rph_pkg::rsp_item_t      rsp_item
);

    logic signed [15:0] level_reg;
    logic signed [15:0] level_next;
    logic               loaded_reg;
    logic               loaded_next;
    logic               near_reg;
    logic               near_next;
    logic [16:0]        age_reg;
    logic [16:0]        age_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    rph_pkg::rsp_item_t rsp_item_reg;
    rph_pkg::rsp_item_t rsp_item_next;

    logic               is_sample;
    logic [8:0]         alpha_eff;
    logic signed [15:0] sample_q88;
    logic signed [16:0] diff;
    logic signed [26:0] prod;
    logic signed [26:0] num;
    logic signed [26:0] num_rnd;
    logic signed [15:0] ema_level;
    logic [17:0]        age_sum;
    logic               present;
    logic signed [16:0] level_rnd;
    logic signed [8:0]  dbm_wide;
    logic signed [7:0]  dbm;

    assign take = item_valid && (!rsp_valid_reg || rsp_ready);

    assign is_sample  = (item.kind == rph_pkg::KIND_SAMPLE);
    assign alpha_eff  = (cfg.alpha > rph_pkg::ALPHA_ONE) ? rph_pkg::ALPHA_ONE : cfg.alpha;
    assign sample_q88 = {item.rssi, 8'h00};

    // EMA written as level*256 + alpha*(sample - level), then divided by 256
    // with ties away from zero: add 127 for negative sums, 128 otherwise.
    assign diff    = {sample_q88[15], sample_q88} - {level_reg[15], level_reg};
    assign prod    = $signed({1'b0, alpha_eff}) * diff;
    assign num     = $signed({{3{level_reg[15]}}, level_reg, 8'h00}) + prod;
    assign num_rnd = num + (num[26] ? 27'sd127 : 27'sd128);
    assign ema_level = num_rnd[23:8];

    assign age_sum = {1'b0, age_reg} + {2'b00, item.elapsed_ms};

    always_comb
    begin
        level_next  = level_reg;
        loaded_next = loaded_reg;
        age_next    = age_reg;
        if (is_sample)
        begin
            level_next  = loaded_reg ? ema_level : sample_q88;
            loaded_next = 1'b1;
            age_next    = '0;
        end
        else
        begin
            age_next = age_sum[17] ? rph_pkg::AGE_MAX : age_sum[16:0];
        end
    end

    assign present = loaded_next && (age_next <= {1'b0, cfg.timeout_ms});

    always_comb
    begin
        near_next = near_reg;
        if (!present)
        begin
            near_next = 1'b0;
        end
        else if (!near_reg)
        begin
            if (level_next >= $signed({cfg.near_threshold, 8'h00}))
            begin
                near_next = 1'b1;
            end
        end
        else
        begin
            if (level_next <= $signed({cfg.far_threshold, 8'h00}))
            begin
                near_next = 1'b0;
            end
        end
    end

    assign level_rnd = {level_next[15], level_next} + (level_next[15] ? 17'sd127 : 17'sd128);
    assign dbm_wide  = level_rnd[16:8];
    assign dbm       = (dbm_wide[8] != dbm_wide[7]) ?
                       (dbm_wide[8] ? -8'sd128 : 8'sd127) : dbm_wide[7:0];

    always_comb
    begin
        rsp_item_next.near         = near_next;
        rsp_item_next.changed      = near_next != near_reg;
        rsp_item_next.peer_present = present;
        rsp_item_next.filtered_dbm = dbm;
    end

    always_comb
    begin
        if (take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= rph_pkg::LEVEL_RESET;
            loaded_reg    <= 1'b0;
            near_reg      <= 1'b0;
            age_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (take)
            begin
                level_reg  <= level_next;
                loaded_reg <= loaded_next;
                near_reg   <= near_next;
                age_reg    <= age_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rsp_item_reg <= rsp_item_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

`default_nettype wire

// ===== hdl/rssi_proximity_hysteresis_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "rssi_proximity_hysteresis_top_assert.svh"

// RSSI proximity detector: each item on req is either an RSSI sample, which
// loads or updates an exponential moving average of the signal level and
// clears the sample age, or a time step, which adds elapsed milliseconds to a
// saturating age. Every item returns exactly one result on rsp: the near/far
// state after hysteresis against the two thresholds, whether it changed, peer
// presence (a sample seen and its age within the timeout) and the filtered
// level rounded to whole dBm. The block takes one item per clock cycle while
// rsp is not stalled: an accepted item sits in the input register while the
// EMA multiplier works on it, and the result register loads when the core
// takes it. A stalled result holds the input register and so stalls req. The
// configuration channel is always ready and should be written only while no
// item is in flight.
module rssi_proximity_hysteresis_top (
    input  wire logic clk,
    input  wire logic rst_n,
    rph_req_if.sink   req,
    rph_rsp_if.source rsp,
    rph_cfg_if.sink   cfg
);

    rph_pkg::cfg_t      cfg_q;
    rph_pkg::req_item_t req_item;
    rph_pkg::req_item_t s1_item;
    rph_pkg::rsp_item_t rsp_item;
    logic               s1_valid;
    logic               s1_take;
    logic               rsp_valid;

    assign cfg.ready = 1'b1;

    rph_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid && cfg.ready),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_q)
    );

    assign req_item.kind       = req.kind;
    assign req_item.rssi       = req.rssi;
    assign req_item.elapsed_ms = req.elapsed_ms;

    rph_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_item   (req_item),
        .in_ready  (req.ready),
        .out_valid (s1_valid),
        .out_item  (s1_item),
        .take      (s1_take)
    );

    rph_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_q),
        .item_valid (s1_valid),
        .item       (s1_item),
        .take       (s1_take),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp.ready),
        .rsp_item   (rsp_item)
    );

    assign rsp.valid        = rsp_valid;
    assign rsp.near         = rsp_item.near;
    assign rsp.changed      = rsp_item.changed;
    assign rsp.peer_present = rsp_item.peer_present;
    assign rsp.filtered_dbm = rsp_item.filtered_dbm;

    // Near can only be reported for a peer that is present.
    `RPH_ASSERT_IMPLY(a_near_needs_peer, clk, rst_n, rsp.valid && rsp.near, rsp.peer_present)

    // A switch to near means the level reached the near threshold.
    `RPH_ASSERT_IMPLY(a_near_switch_level, clk, rst_n,
        rsp.valid && rsp.changed && rsp.near, rsp.filtered_dbm >= cfg_q.near_threshold)

    // An item left in the input register by a stalled core stays there unchanged.
    `RPH_ASSERT_NEXT(a_stage_holds, clk, rst_n,
        s1_valid && !s1_take, s1_valid && $stable(s1_item))

endmodule

`default_nettype wire

// ===== tb/sv/tb_rssi_proximity_hysteresis_top.sv =====
`timescale 1ns / 1ps

module tb_rssi_proximity_hysteresis_top;

    localparam int QUIET_LIMIT  = 3000;
    localparam int PHASE_ITEMS  = 190;
    localparam int PHASE_COUNT  = 8;
    localparam int HOLD_AT      = 700;
    localparam int HOLD_CYCLES  = 400;

    // Tracks the filter, age and proximity state and keeps the results that
    // accepted items are due to produce, oldest first.
    class proximity_scoreboard;
        rph_pkg::cfg_t      regs;
        logic signed [15:0] level;
        bit                 loaded;
        bit                 near_state;
        logic [16:0]        age;
        rph_pkg::rsp_item_t expected_q[$];
        int                 errors;
        int                 checked;

        function new();
            regs.alpha          = rph_pkg::ALPHA_RESET;
            regs.near_threshold = rph_pkg::NEAR_THR_RESET;
            regs.far_threshold  = rph_pkg::FAR_THR_RESET;
            regs.timeout_ms     = rph_pkg::TIMEOUT_RESET;
            level      = rph_pkg::LEVEL_RESET;
            loaded     = 1'b0;
            near_state = 1'b0;
            age        = '0;
            errors     = 0;
            checked    = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                rph_pkg::CFG_ALPHA:          regs.alpha = data[8:0];
                rph_pkg::CFG_NEAR_THRESHOLD: regs.near_threshold = data[7:0];
                rph_pkg::CFG_FAR_THRESHOLD:  regs.far_threshold = data[7:0];
                rph_pkg::CFG_TIMEOUT_MS:     regs.timeout_ms = data;
                default:                     ;
            endcase
        endfunction

        // Divide by 256, rounding to nearest with ties away from zero.
        function longint div_round_q8(longint n);
            longint mag;
            longint q;
            mag = (n < 0) ? -n : n;
            q = (mag + 128) >>> 8;
            return (n < 0) ? -q : q;
        endfunction

        function void note_input(rph_pkg::req_item_t it);
            rph_pkg::rsp_item_t want;
            longint             num;
            longint             dbm;
            int                 a;
            int                 sum;
            int                 lvl;
            bit                 prev;
            bit                 present;
            prev = near_state;
            if (it.kind == rph_pkg::KIND_SAMPLE)
            begin
                if (!loaded)
                begin
                    level  = {it.rssi, 8'h00};
                    loaded = 1'b1;
                end
                else
                begin
                    a = (regs.alpha > rph_pkg::ALPHA_ONE) ? 256 : int'(regs.alpha);
                    num = longint'(a) * (longint'($signed(it.rssi)) * 256)
                        + longint'(256 - a) * longint'($signed(level));
                    level = 16'(div_round_q8(num));
                end
                age = '0;
            end
            else
            begin
                sum = int'(age) + int'(it.elapsed_ms);
                age = (sum > int'(rph_pkg::AGE_MAX)) ? rph_pkg::AGE_MAX : 17'(sum);
            end

            lvl = $signed(level);
            if (!loaded || age > {1'b0, regs.timeout_ms})
                near_state = 1'b0;
            else if (!near_state)
            begin
                if (lvl >= int'($signed(regs.near_threshold)) * 256)
                    near_state = 1'b1;
            end
            else if (lvl <= int'($signed(regs.far_threshold)) * 256)
                near_state = 1'b0;

            present = loaded && (age <= {1'b0, regs.timeout_ms});
            dbm = div_round_q8(longint'(lvl));
            if (dbm > 127)
                dbm = 127;
            if (dbm < -128)
                dbm = -128;

            want.near         = near_state;
            want.changed      = (near_state != prev);
            want.peer_present = present;
            want.filtered_dbm = 8'(dbm);
            expected_q.push_back(want);
        endfunction

        task report(string msg);
            $display("mismatch at result %0d: %s", checked, msg);
            errors++;
        endtask

        task check_result(rph_pkg::rsp_item_t got);
            rph_pkg::rsp_item_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result %h arrived with nothing outstanding", got));
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.near !== want.near)
                    report($sformatf("near %b, want %b", got.near, want.near));
                if (got.changed !== want.changed)
                    report($sformatf("changed %b, want %b", got.changed, want.changed));
                if (got.peer_present !== want.peer_present)
                    report($sformatf("peer_present %b, want %b",
                                     got.peer_present, want.peer_present));
                if (got.filtered_dbm !== want.filtered_dbm)
                    report($sformatf("filtered_dbm %0d, want %0d",
                                     got.filtered_dbm, want.filtered_dbm));
            end
            checked++;
        endtask
    endclass

    logic clk;
    logic rst_n;
    bit   calm;
    int   results_seen = 0;
    int   quiet_cycles = 0;
    int   phase_near;
    int   phase_far;
    int   phase_timeout;

    proximity_scoreboard sb = new();

    rph_req_if req_if ();
    rph_rsp_if rsp_if ();
    rph_cfg_if cfg_if ();

    rssi_proximity_hysteresis_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: random back-pressure, plus one long hold-off once the
    // stream is well under way so that the block fills and stalls its input.
    initial
    begin : result_sink
        int hold_left;
        bit held;
        hold_left = 0;
        held = 1'b0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && results_seen >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                held = 1'b1;
            end
            if (hold_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_if.ready <= calm || ($urandom_range(99) >= 24);
        end
    end

    always @(posedge clk)
    begin : result_monitor
        rph_pkg::rsp_item_t got;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got.near         = rsp_if.near;
            got.changed      = rsp_if.changed;
            got.peer_present = rsp_if.peer_present;
            got.filtered_dbm = rsp_if.filtered_dbm;
            sb.check_result(got);
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_item(input logic kind, input logic signed [7:0] rssi,
                             input logic [15:0] elapsed);
        rph_pkg::req_item_t it;
        while (!calm && $urandom_range(99) < 24)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.kind       <= kind;
        req_if.rssi       <= rssi;
        req_if.elapsed_ms <= elapsed;
        it.kind       = kind;
        it.rssi       = rssi;
        it.elapsed_ms = elapsed;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        sb.note_input(it);
        @(negedge clk);
    endtask

    // The unused field of each kind carries random bits; the block must ignore them.
    task automatic send_sample(input int rssi);
        send_item(rph_pkg::KIND_SAMPLE, 8'(rssi), 16'($urandom()));
    endtask

    task automatic send_step(input int elapsed);
        send_item(rph_pkg::KIND_STEP, 8'($urandom()), 16'(elapsed));
    endtask

    // Stops offering items and lets the block empty before a register write.
    task automatic quiesce();
        req_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    // Unused upper bits of the data word are filled at random.
    task automatic set_config(input int alpha, input int near_thr, input int far_thr,
                              input int timeout);
        write_reg(rph_pkg::CFG_ALPHA, {7'($urandom()), 9'(alpha)});
        write_reg(rph_pkg::CFG_NEAR_THRESHOLD, {8'($urandom()), 8'(near_thr)});
        write_reg(rph_pkg::CFG_FAR_THRESHOLD, {8'($urandom()), 8'(far_thr)});
        write_reg(rph_pkg::CFG_TIMEOUT_MS, 16'(timeout));
        cfg_if.valid <= 1'b0;
        phase_near    = near_thr;
        phase_far     = far_thr;
        phase_timeout = timeout;
    endtask

    task automatic random_config();
        int alpha;
        int near_thr;
        int far_thr;
        int timeout;
        case ($urandom_range(5))
            0:       alpha = 0;
            1:       alpha = 256;
            2:       alpha = $urandom_range(511, 257);
            3:       alpha = $urandom_range(511);
            default: alpha = $urandom_range(255, 1);
        endcase
        if ($urandom_range(3) == 0)
        begin
            near_thr = int'($urandom_range(255)) - 128;
            far_thr  = int'($urandom_range(255)) - 128;
        end
        else
        begin
            near_thr = int'($urandom_range(60)) - 90;
            far_thr  = near_thr - int'($urandom_range(20));
        end
        case ($urandom_range(5))
            0:       timeout = 0;
            1:       timeout = 65535;
            2:       timeout = $urandom_range(65535);
            default: timeout = $urandom_range(5000);
        endcase
        set_config(alpha, near_thr, far_thr, timeout);
    endtask

    // Mostly samples clustered around the thresholds so that the hysteresis is
    // exercised, with time steps that now and then let the peer time out.
    task automatic run_phase(input int count);
        int centre;
        int span;
        int r;
        int e;
        centre = (phase_near + phase_far) / 2;
        span   = 4 + (phase_near - phase_far) * ((phase_near > phase_far) ? 1 : -1);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 65)
            begin
                if ($urandom_range(99) < 15)
                    r = int'($urandom_range(255)) - 128;
                else
                    r = centre + int'($urandom_range(2 * span)) - span;
                if (r > 127)
                    r = 127;
                if (r < -128)
                    r = -128;
                send_sample(r);
            end
            else
            begin
                case ($urandom_range(19))
                    0:       e = $urandom_range(65535);
                    1:       e = phase_timeout;
                    2:       e = 0;
                    default: e = $urandom_range(phase_timeout / 3 + 20);
                endcase
                send_step(e);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        calm  = 1'b0;
        phase_near    = -60;
        phase_far     = -70;
        phase_timeout = 3000;
        req_if.valid      = 1'b0;
        req_if.kind       = rph_pkg::KIND_SAMPLE;
        req_if.rssi       = '0;
        req_if.elapsed_ms = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = rph_pkg::CFG_ALPHA;
        cfg_if.data  = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: steps before any sample, then the age saturating.
        send_step(0);
        send_step(65535);
        send_step(65535);
        send_step(65535);
        send_sample(-50);
        send_sample(-128);
        send_sample(-128);
        send_sample(127);
        send_step(3000);
        send_step(1);
        send_sample(-100);
        send_sample(0);

        // Unit alpha, extreme thresholds and a zero timeout.
        quiesce();
        set_config(256, 127, -128, 0);
        send_sample(127);
        send_sample(127);
        send_step(0);
        send_step(1);
        send_sample(-128);

        // Alpha above one, far threshold above near, longest timeout.
        quiesce();
        set_config(511, -128, 127, 65535);
        send_sample(5);
        send_sample(126);
        send_step(65535);
        send_step(1);
        send_sample(-1);

        // Zero alpha leaves the level where it is.
        quiesce();
        set_config(0, -60, -70, 3000);
        send_sample(127);
        send_sample(-128);
        send_step(100);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            quiesce();
            random_config();
            calm = (p == 2);
            run_phase(PHASE_ITEMS);
        end
        calm = 1'b0;

        req_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
